// ----- rtl/multi_level_usage_alarm_defines.svh -----
// Assertion macros for the multi-level usage alarm.
// Used by the top level only; expects a clock named clk and reset rst.
`ifndef MULTI_LEVEL_USAGE_ALARM_DEFINES_SVH
`define MULTI_LEVEL_USAGE_ALARM_DEFINES_SVH

// same-cycle implication
`define MLUA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MLUA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mlua_pkg.sv -----
// Shared constants and types for the multi-level usage alarm.
// No dependencies.
package mlua_pkg;

  localparam int NUM_LEVELS = 7;
  localparam int CNT_W      = 16;
  localparam int REF_W      = 17;
  localparam int LVL_W      = 3;
  localparam int HYST_W     = 7;
  localparam int LIM_W      = 32;
  localparam int PERCENT    = 100;
  localparam int PROD_W     = 24;

  localparam logic [LVL_W-1:0] CFG_HYST = 3'd7;

  localparam logic KIND_MAX  = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [LVL_W-1:0] level;
    logic             kind;
    logic [CNT_W-1:0] count;
    logic [REF_W-1:0] ref_val;
  } slot_t;

  typedef struct packed {
    logic start;
    logic div_en;
    logic eval;
    logic shift;
  } cell_ctrl_t;

endpackage

// ----- rtl/multi_level_usage_alarm.sv -----
// Multi-level usage alarm: a row of seven level cells fed by one sequencer.
// Each item is accepted, divided (one quotient bit per cycle in every cell) and
// evaluated once the previous item's results have all gone out; the result of
// level k then shifts through k slots to the output, plus any output stall.
// The next item may be accepted and divide while results drain. Reset (rst,
// synchronous) clears config registers, sequencer, level state, slot valid bits.
`include "multi_level_usage_alarm_defines.svh"

module multi_level_usage_alarm (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // usage_count
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // alarm_level, reported_count, reference_value
  output logic        m_axis_tuser,   // alarm_kind
  output logic        m_axis_tlast,   // last_of_run
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EVAL = 3'b100
  } state_t;

  state_t state, state_next;
  logic [3:0] div_cnt;
  logic [mlua_pkg::CNT_W-1:0]  cnt_q;
  logic [mlua_pkg::LIM_W-1:0]  limits [mlua_pkg::NUM_LEVELS];
  logic [mlua_pkg::HYST_W-1:0] hyst;
  mlua_pkg::slot_t    slots [mlua_pkg::NUM_LEVELS];
  mlua_pkg::cell_ctrl_t ctrl;
  logic any_valid, tail_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mlua_pkg::NUM_LEVELS; i++) limits[i] <= '0;
      hyst <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == mlua_pkg::CFG_HYST) hyst <= cfg_wdata[mlua_pkg::HYST_W-1:0];
      else limits[cfg_addr] <= cfg_wdata;
    end
  end

  always_comb begin
    any_valid  = slots[0].valid;
    tail_valid = 1'b0;
    for (int i = 1; i < mlua_pkg::NUM_LEVELS; i++) tail_valid = tail_valid | slots[i].valid;
    any_valid = any_valid | tail_valid;
  end

  assign s_axis_tready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next  = state;
    ctrl.start  = 1'b0;
    ctrl.div_en = 1'b0;
    ctrl.eval   = 1'b0;
    ctrl.shift  = !slots[0].valid || m_axis_tready;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          ctrl.start = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        ctrl.div_en = 1'b1;
        if (div_cnt == 4'hF) state_next = S_EVAL;
      end
      S_EVAL: begin
        // wait until the previous item's results have all gone out
        if (!any_valid) begin
          ctrl.eval  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      if (ctrl.start) div_cnt <= '0;
      else if (ctrl.div_en) div_cnt <= div_cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) cnt_q <= s_axis_tdata;
  end

  for (genvar g = 0; g < mlua_pkg::NUM_LEVELS; g++) begin : g_cell
    mlua_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .limits  (limits[g]),
      .hyst    (hyst),
      .cnt     (ctrl.start ? s_axis_tdata : cnt_q),
      .level   (mlua_pkg::LVL_W'(g)),
      .slot_in ((g == mlua_pkg::NUM_LEVELS - 1) ? '0 : slots[(g + 1) % mlua_pkg::NUM_LEVELS]),
      .slot    (slots[g])
    );
  end

  assign m_axis_tvalid = slots[0].valid;
  assign m_axis_tdata  = {4'd0, slots[0].ref_val, slots[0].count, slots[0].level};
  assign m_axis_tuser  = slots[0].kind;
  assign m_axis_tlast  = slots[0].valid && !tail_valid;

  `MLUA_ASSERT_NEXT(a_accept_divides, s_axis_tvalid && s_axis_tready, state == S_DIV, "accept did not start divide")
  `MLUA_ASSERT_NEXT(a_eval_done, state == S_EVAL && !any_valid, state == S_IDLE, "evaluate stalled")
  `MLUA_ASSERT_IMPL(a_last_valid, m_axis_tlast, m_axis_tvalid, "tlast without tvalid")
  `MLUA_ASSERT_IMPL(a_no_eval_busy, ctrl.eval, !any_valid, "evaluate over pending results")

endmodule

// ----- rtl/mlua_cell.sv -----
// One alarm level: state, two bit-serial dividers and a result slot
// that shifts toward the output end of the row. Uses mlua_pkg.
module mlua_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  mlua_pkg::cell_ctrl_t         ctrl,
  input  logic [mlua_pkg::LIM_W-1:0]   limits,
  input  logic [mlua_pkg::HYST_W-1:0]  hyst,
  input  logic [mlua_pkg::CNT_W-1:0]   cnt,
  input  logic [mlua_pkg::LVL_W-1:0]   level,
  input  mlua_pkg::slot_t              slot_in,
  output mlua_pkg::slot_t              slot
);

  logic [mlua_pkg::CNT_W-1:0]  last;
  logic                        flag;
  logic [mlua_pkg::CNT_W-1:0]  qc, rc, ql, rl;
  logic [mlua_pkg::CNT_W:0]    tc, tl;
  logic [mlua_pkg::CNT_W-1:0]  step, mx;
  logic                        step_x, ge, notify, clr;
  logic [mlua_pkg::PROD_W-1:0] prod, lim;

  assign step = limits[15:0];
  assign mx   = limits[31:16];
  assign tc   = {rc, qc[mlua_pkg::CNT_W-1]};
  assign tl   = {rl, ql[mlua_pkg::CNT_W-1]};

  always_comb begin
    ge     = cnt >= mx;
    step_x = (step != '0) && (qc > ql) && (cnt <= mx);
    notify = (mx != '0) && (step_x || (ge && !flag));
    // floor(mx*h/100) <= mx-cnt  <=>  mx*h <= 100*(mx-cnt)+99
    prod   = mlua_pkg::PROD_W'(mx) * mlua_pkg::PROD_W'(hyst);
    lim    = mlua_pkg::PROD_W'(mx - cnt) * mlua_pkg::PROD_W'(mlua_pkg::PERCENT)
             + mlua_pkg::PROD_W'(mlua_pkg::PERCENT - 1);
    clr    = (mx != '0) && !ge && flag && (prod <= lim);
  end

  // restoring dividers, quotient builds in place of the dividend
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      qc <= cnt;
      rc <= '0;
      ql <= last;
      rl <= '0;
    end else if (ctrl.div_en) begin
      if (tc >= {1'b0, step}) begin
        rc <= mlua_pkg::CNT_W'(tc - {1'b0, step});
        qc <= {qc[mlua_pkg::CNT_W-2:0], 1'b1};
      end else begin
        rc <= tc[mlua_pkg::CNT_W-1:0];
        qc <= {qc[mlua_pkg::CNT_W-2:0], 1'b0};
      end
      if (tl >= {1'b0, step}) begin
        rl <= mlua_pkg::CNT_W'(tl - {1'b0, step});
        ql <= {ql[mlua_pkg::CNT_W-2:0], 1'b1};
      end else begin
        rl <= tl[mlua_pkg::CNT_W-1:0];
        ql <= {ql[mlua_pkg::CNT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
      last       <= '0;
      flag       <= 1'b0;
    end else if (ctrl.eval) begin
      slot.valid <= notify;
      slot.level <= level;
      slot.count <= cnt;
      if (ge) begin
        slot.kind    <= mlua_pkg::KIND_MAX;
        slot.ref_val <= {1'b0, mx};
      end else begin
        slot.kind    <= mlua_pkg::KIND_STEP;
        // (cnt/step + 1) * step
        slot.ref_val <= {1'b0, cnt} - {1'b0, rc} + {1'b0, step};
      end
      if (notify) last <= cnt;
      if ((mx != '0) && ge && !step_x && !flag) flag <= 1'b1;
      else if (clr) flag <= 1'b0;
    end else if (ctrl.shift) begin
      slot <= slot_in;
    end
  end

endmodule

// ----- dv/multi_level_usage_alarm_test.sv -----
// Self-checking testbench for the seven-level usage alarm.
// Drives usage counts on the input stream and checks every alarm item against
// a built-in predictor. Depends on mlua_pkg and the multi_level_usage_alarm RTL.
`timescale 1ns / 100ps

module multi_level_usage_alarm_test;

  typedef struct packed {
    logic [mlua_pkg::LVL_W-1:0] level;
    logic                       kind;
    logic [mlua_pkg::CNT_W-1:0] count;
    logic [mlua_pkg::REF_W-1:0] ref_val;
    logic                       last;
  } alarm_t;

  localparam int WDOG_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  // predictor state
  logic [mlua_pkg::LIM_W-1:0]  limits[mlua_pkg::NUM_LEVELS];
  logic [mlua_pkg::HYST_W-1:0] hyst_pct;
  logic [mlua_pkg::CNT_W-1:0]  last_cnt[mlua_pkg::NUM_LEVELS];
  logic                        reached[mlua_pkg::NUM_LEVELS];

  alarm_t alarm_q[$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     calm = 1'b0;

  multi_level_usage_alarm u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string what);
    errors++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // predict the alarms caused by one count and update the level state
  task automatic predict_alarms(input logic [15:0] cnt);
    alarm_t     a;
    int         n;
    int         lead;
    logic [15:0] stp;
    logic [15:0] mx;
    bit         hit;
    int         thr;
    n = 0;
    lead = alarm_q.size();
    for (int lv = 0; lv < mlua_pkg::NUM_LEVELS; lv++) begin
      stp = limits[lv][15:0];
      mx  = limits[lv][31:16];
      hit = 1'b0;
      if (mx != 0) begin
        if (stp != 0 && (cnt / stp) > (last_cnt[lv] / stp) && cnt <= mx) hit = 1'b1;
        if (cnt >= mx) begin
          if (!hit && !reached[lv]) begin
            reached[lv] = 1'b1;
            hit = 1'b1;
          end
        end else if (reached[lv]) begin
          thr = int'(mx) - int'((32'(mx) * 32'(hyst_pct)) / mlua_pkg::PERCENT);
          if (int'(cnt) <= thr) reached[lv] = 1'b0;
        end
        if (hit) begin
          a.level = mlua_pkg::LVL_W'(lv);
          a.count = cnt;
          a.last  = 1'b0;
          if (cnt >= mx) begin
            a.kind = mlua_pkg::KIND_MAX;
            a.ref_val = mlua_pkg::REF_W'(mx);
          end else begin
            a.kind = mlua_pkg::KIND_STEP;
            a.ref_val = mlua_pkg::REF_W'((32'(cnt) / stp + 1) * stp);
          end
          last_cnt[lv] = cnt;
          alarm_q.push_back(a);
          n++;
        end
      end
    end
    if (n > 0) alarm_q[lead + n - 1].last = 1'b1;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == mlua_pkg::CFG_HYST) hyst_pct = val[mlua_pkg::HYST_W-1:0];
    else limits[idx] = val;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (alarm_q.size() != 0) @(posedge clk);
    // items that produce nothing may still be in flight
    repeat (40) @(posedge clk);
  endtask

  task automatic send_count(input logic [15:0] cnt);
    if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cnt;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_alarms(cnt);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (!calm && $urandom_range(0, 3) == 0) m_axis_tready <= 1'b0;
      else m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    alarm_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (alarm_q.size() == 0) begin
        report($sformatf("unexpected alarm tdata=%h", m_axis_tdata));
      end else begin
        e = alarm_q.pop_front();
        if (m_axis_tdata[2:0] != e.level)
          report($sformatf("level %0d exp %0d", m_axis_tdata[2:0], e.level));
        if (m_axis_tdata[18:3] != e.count)
          report($sformatf("count %0d exp %0d", m_axis_tdata[18:3], e.count));
        if (m_axis_tdata[35:19] != e.ref_val)
          report($sformatf("ref %0d exp %0d", m_axis_tdata[35:19], e.ref_val));
        if (m_axis_tdata[39:36] != 4'd0) report("nonzero pad bits");
        if (m_axis_tuser != e.kind) report($sformatf("kind exp %0d", e.kind));
        if (m_axis_tlast != e.last) report($sformatf("last exp %0d", e.last));
      end
    end
  end

  // ends the run after a long stretch with no accepted item
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic test_steps_and_max();
    write_reg(3'd0, {16'd100, 16'd10});
    write_reg(3'd1, {16'd50, 16'd0});
    write_reg(3'd2, {16'hFFFF, 16'hFFFF});
    write_reg(3'd3, {16'd1, 16'd1});
    write_reg(3'd4, {16'd0, 16'd5});
    write_reg(3'd5, {16'd40, 16'd7});
    write_reg(3'd6, {16'd30, 16'd3});
    write_reg(mlua_pkg::CFG_HYST, 32'd20);
    send_count(16'd0);
    send_count(16'd9);
    send_count(16'd10);
    send_count(16'd35);
    send_count(16'd50);     // exactly at the maximum of level 1
    send_count(16'd100);
    send_count(16'd200);    // above the maximum
    send_count(16'd90);     // inside the hysteresis band
    send_count(16'd79);     // below it: the reached flag of level 0 clears
    send_count(16'd100);
    send_count(16'hFFFF);
    send_count(16'hFFFE);
    send_count(16'd1);
    wait_drained();
  endtask

  task automatic test_hysteresis_extremes();
    write_reg(mlua_pkg::CFG_HYST, 32'd127);   // threshold negative except at level 3; those flags stick
    send_count(16'd0);
    send_count(16'd100);
    send_count(16'd0);
    wait_drained();
    write_reg(mlua_pkg::CFG_HYST, 32'd100);
    send_count(16'd0);
    send_count(16'd200);
    send_count(16'd0);
    send_count(16'd100);
    wait_drained();
    write_reg(mlua_pkg::CFG_HYST, 32'd0);
    send_count(16'd99);
    send_count(16'd100);
    wait_drained();
  endtask

  task automatic test_random(input int items);
    logic [15:0] mx;
    logic [15:0] cnt;
    for (int phase = 0; phase < 4; phase++) begin
      for (int lv = 0; lv < mlua_pkg::NUM_LEVELS; lv++) begin
        case ($urandom_range(0, 3))
          0: write_reg(3'(lv), $urandom());
          1: write_reg(3'(lv), 32'd0);
          default: write_reg(3'(lv), {16'($urandom_range(1, 400)),
                                      16'($urandom_range(0, 60))});
        endcase
      end
      write_reg(mlua_pkg::CFG_HYST, 32'($urandom_range(0, 127)));
      if (phase == 3) calm = 1'b1;
      for (int k = 0; k < items / 4; k++) begin
        mx = limits[$urandom_range(0, mlua_pkg::NUM_LEVELS - 1)][31:16];
        case ($urandom_range(0, 5))
          0: cnt = 16'($urandom());
          1: cnt = mx;
          2: cnt = mx + 16'($urandom_range(0, 3));
          default: cnt = 16'($urandom_range(0, 450));
        endcase
        send_count(cnt);
        if (k == 20) wait_drained();
      end
      wait_drained();
    end
  endtask

  initial begin
    foreach (limits[i]) begin
      limits[i] = '0;
      last_cnt[i] = '0;
      reached[i] = 1'b0;
    end
    hyst_pct = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_steps_and_max();
    test_hysteresis_extremes();
    test_random(248);
    wait_drained();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
